### src/nnsa_pkg.sv
// Shared types and constants for the nearest-neighbour scaling address generator.
// No dependencies; every other file takes names from here by scope.
`default_nettype none

package nnsa_pkg;

   localparam int DIM_W     = 11;            // pixel coordinate and size width
   localparam int PB_W      = 3;             // bytes-per-pixel width
   localparam int LIN_W     = 2 * DIM_W;     // linear pixel index and scaled product
   localparam int OFS_W     = 24;            // byte offset width
   localparam int DIV_STEPS = DIM_W;         // one quotient bit per divider stage
   localparam int NSTG      = DIV_STEPS + 3; // front, divider, combine, output
   localparam int STG_DIV0  = 1;
   localparam int STG_BACK  = DIV_STEPS + 1;

   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_BYTES   = 3'd4;

   localparam logic [PB_W-1:0] PB_MAX = 3'd4;

   typedef struct packed {
      logic [DIM_W-1:0] source_width;
      logic [DIM_W-1:0] source_height;
      logic [DIM_W-1:0] target_width;
      logic [DIM_W-1:0] target_height;
      logic [PB_W-1:0]  pixel_bytes;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      source_width:  11'd1,
      source_height: 11'd1,
      target_width:  11'd0,
      target_height: 11'd0,
      pixel_bytes:   3'd2
   };

   // Per-request data carried alongside the divider
   typedef struct packed {
      logic [DIM_W-1:0] out_x;
      logic [DIM_W-1:0] out_y;
      logic             ok;
      logic             scaling;
      logic [LIN_W-1:0] dst_lin;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [LIN_W-1:0] prod_x;
      logic [LIN_W-1:0] prod_y;
   } front_type;

endpackage

`default_nettype wire

### src/nnsa_front.sv
// First pipeline stage: range checks, scaling products and target linear index.
// Depends on nnsa_pkg.
`default_nettype none

module nnsa_front (
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire nnsa_pkg::cfg_type       cfg,
   input  wire logic [nnsa_pkg::DIM_W-1:0] out_x,
   input  wire logic [nnsa_pkg::DIM_W-1:0] out_y,
   output nnsa_pkg::front_type          front_out
);

   nnsa_pkg::front_type front_ff, front_in;
   logic [nnsa_pkg::DIM_W-1:0] frame_w, frame_h;
   logic                       scaling, ok;

   always_comb begin
      scaling = (cfg.target_width != '0) && (cfg.target_height != '0);
      frame_w = scaling ? cfg.target_width  : cfg.source_width;
      frame_h = scaling ? cfg.target_height : cfg.source_height;
      ok = (cfg.source_width != '0) && (cfg.source_height != '0)
           && (cfg.pixel_bytes != '0) && (cfg.pixel_bytes <= nnsa_pkg::PB_MAX)
           && (out_x < frame_w) && (out_y < frame_h);

      front_in.side.out_x   = out_x;
      front_in.side.out_y   = out_y;
      front_in.side.ok      = ok;
      front_in.side.scaling = scaling;
      front_in.side.dst_lin = nnsa_pkg::LIN_W'(out_y) * nnsa_pkg::LIN_W'(frame_w)
                              + nnsa_pkg::LIN_W'(out_x);
      front_in.prod_x = nnsa_pkg::LIN_W'(out_x) * nnsa_pkg::LIN_W'(cfg.source_width);
      front_in.prod_y = nnsa_pkg::LIN_W'(out_y) * nnsa_pkg::LIN_W'(cfg.source_height);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign front_out = front_ff;

endmodule

`default_nettype wire

### src/nnsa_div.sv
// Pipelined restoring divider for both axes, one quotient bit per stage.
// Depends on nnsa_pkg.
`default_nettype none

module nnsa_div (
   input  wire logic                              clock,
   input  wire logic [nnsa_pkg::DIV_STEPS-1:0]    en,
   input  wire nnsa_pkg::front_type               front_in,
   input  wire logic [nnsa_pkg::DIM_W-1:0]        div_x,
   input  wire logic [nnsa_pkg::DIM_W-1:0]        div_y,
   output nnsa_pkg::side_type                     side_out,
   output logic [nnsa_pkg::DIM_W-1:0]             quot_x,
   output logic [nnsa_pkg::DIM_W-1:0]             quot_y
);

   localparam int W = nnsa_pkg::DIM_W;
   localparam int S = nnsa_pkg::DIV_STEPS;

   logic [W-1:0] rx_ff [S];
   logic [W-1:0] nx_ff [S];
   logic [W-1:0] qx_ff [S];
   logic [W-1:0] ry_ff [S];
   logic [W-1:0] ny_ff [S];
   logic [W-1:0] qy_ff [S];
   nnsa_pkg::side_type side_ff [S];

   for (genvar k = 0; k < S; k++) begin : g_step
      logic [W-1:0] rx_p, nx_p, qx_p, ry_p, ny_p, qy_p;
      logic [W-1:0] rx_in, nx_in, qx_in, ry_in, ny_in, qy_in;
      logic [W:0]   tx, ty, dx, dy;
      logic         gex, gey;
      nnsa_pkg::side_type side_p;

      // The dividend's upper half is below the divisor for any in-frame request,
      // so the remainder always fits the divisor width.
      if (k == 0) begin : g_first
         assign rx_p   = front_in.prod_x[2*W-1:W];
         assign nx_p   = front_in.prod_x[W-1:0];
         assign qx_p   = '0;
         assign ry_p   = front_in.prod_y[2*W-1:W];
         assign ny_p   = front_in.prod_y[W-1:0];
         assign qy_p   = '0;
         assign side_p = front_in.side;
      end else begin : g_next
         assign rx_p   = rx_ff[k-1];
         assign nx_p   = nx_ff[k-1];
         assign qx_p   = qx_ff[k-1];
         assign ry_p   = ry_ff[k-1];
         assign ny_p   = ny_ff[k-1];
         assign qy_p   = qy_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      always_comb begin
         tx  = {rx_p, nx_p[W-1]};
         ty  = {ry_p, ny_p[W-1]};
         dx  = tx - {1'b0, div_x};
         dy  = ty - {1'b0, div_y};
         gex = tx >= {1'b0, div_x};
         gey = ty >= {1'b0, div_y};
         rx_in = gex ? dx[W-1:0] : tx[W-1:0];
         ry_in = gey ? dy[W-1:0] : ty[W-1:0];
         nx_in = {nx_p[W-2:0], 1'b0};
         ny_in = {ny_p[W-2:0], 1'b0};
         qx_in = {qx_p[W-2:0], gex};
         qy_in = {qy_p[W-2:0], gey};
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rx_ff[k]   <= rx_in;
            nx_ff[k]   <= nx_in;
            qx_ff[k]   <= qx_in;
            ry_ff[k]   <= ry_in;
            ny_ff[k]   <= ny_in;
            qy_ff[k]   <= qy_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign side_out = side_ff[S-1];
   assign quot_x   = qx_ff[S-1];
   assign quot_y   = qy_ff[S-1];

endmodule

`default_nettype wire

### src/nnsa_back.sv
// Last two stages: source coordinate select, linear indices to byte offsets.
// Depends on nnsa_pkg.
`default_nettype none

module nnsa_back (
   input  wire logic                        clock,
   input  wire logic [1:0]                  en,
   input  wire nnsa_pkg::cfg_type           cfg,
   input  wire nnsa_pkg::side_type          side_in,
   input  wire logic [nnsa_pkg::DIM_W-1:0]  quot_x,
   input  wire logic [nnsa_pkg::DIM_W-1:0]  quot_y,
   output logic [nnsa_pkg::DIM_W-1:0]       src_x,
   output logic [nnsa_pkg::DIM_W-1:0]       src_y,
   output logic [nnsa_pkg::OFS_W-1:0]       src_offset,
   output logic [nnsa_pkg::OFS_W-1:0]       dst_offset,
   output logic                             coord_valid
);

   localparam int W  = nnsa_pkg::DIM_W;
   localparam int LW = nnsa_pkg::LIN_W;
   localparam int OW = nnsa_pkg::OFS_W;

   // combine stage
   logic [W-1:0]  sx_in, sy_in, sx_ff, sy_ff;
   logic [LW-1:0] src_lin_in, src_lin_ff;
   logic [OW-1:0] dst_ofs_in, dst_ofs_ff;
   logic          ok_ff;

   // output stage
   logic [W-1:0]  src_x_ff, src_y_ff;
   logic [OW-1:0] src_ofs_ff, dst_ofs_out_ff, src_ofs_in;
   logic          valid_ff;

   always_comb begin
      sx_in      = side_in.scaling ? quot_x : side_in.out_x;
      sy_in      = side_in.scaling ? quot_y : side_in.out_y;
      src_lin_in = LW'(sy_in) * LW'(cfg.source_width) + LW'(sx_in);
      dst_ofs_in = OW'(side_in.dst_lin) * OW'(cfg.pixel_bytes);
      src_ofs_in = OW'(src_lin_ff) * OW'(cfg.pixel_bytes);
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         src_lin_ff <= src_lin_in;
         dst_ofs_ff <= dst_ofs_in;
         ok_ff      <= side_in.ok;
      end
      if (en[1]) begin
         // out-of-frame requests report all zeros
         src_x_ff       <= ok_ff ? sx_ff      : '0;
         src_y_ff       <= ok_ff ? sy_ff      : '0;
         src_ofs_ff     <= ok_ff ? src_ofs_in : '0;
         dst_ofs_out_ff <= ok_ff ? dst_ofs_ff : '0;
         valid_ff       <= ok_ff;
      end
   end

   assign src_x       = src_x_ff;
   assign src_y       = src_y_ff;
   assign src_offset  = src_ofs_ff;
   assign dst_offset  = dst_ofs_out_ff;
   assign coord_valid = valid_ff;

endmodule

`default_nettype wire

### src/nearest_neighbor_scale_address_top.sv
// Path: an accepted request passes the front, divider, combine and output registers to the rsp_ port.
// Throughput: one request per cycle while rsp_stall is low; the 11-stage divider (one quotient bit per stage)
// sets the depth. Each stage holds its own valid bit, so bubbles close up under stall.
// Reset: valid bits clear and the configuration registers take their reset values;
// datapath registers are not reset.
// Top level; depends on nnsa_pkg, nnsa_front, nnsa_div and nnsa_back.
`default_nettype none

module nearest_neighbor_scale_address_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [nnsa_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [nnsa_pkg::DIM_W-1:0]        csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [nnsa_pkg::DIM_W-1:0]        req_out_x,
   input  wire logic [nnsa_pkg::DIM_W-1:0]        req_out_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [nnsa_pkg::DIM_W-1:0]             rsp_src_x,
   output logic [nnsa_pkg::DIM_W-1:0]             rsp_src_y,
   output logic [nnsa_pkg::OFS_W-1:0]             rsp_src_offset,
   output logic [nnsa_pkg::OFS_W-1:0]             rsp_dst_offset,
   output logic                                   rsp_coord_valid
);

   localparam int N = nnsa_pkg::NSTG;

   nnsa_pkg::cfg_type   cfg_ff;
   nnsa_pkg::front_type front_q;
   nnsa_pkg::side_type  side_q;
   logic [nnsa_pkg::DIM_W-1:0] quot_x, quot_y;

   logic [N-1:0] vld_ff, vld_in, ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= nnsa_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            nnsa_pkg::CSR_SOURCE_WIDTH:  cfg_ff.source_width  <= csr_wdata;
            nnsa_pkg::CSR_SOURCE_HEIGHT: cfg_ff.source_height <= csr_wdata;
            nnsa_pkg::CSR_TARGET_WIDTH:  cfg_ff.target_width  <= csr_wdata;
            nnsa_pkg::CSR_TARGET_HEIGHT: cfg_ff.target_height <= csr_wdata;
            nnsa_pkg::CSR_PIXEL_BYTES:
               cfg_ff.pixel_bytes <= csr_wdata[nnsa_pkg::PB_W-1:0];
            default: ;
         endcase
      end
   end

   // a stage loads when it is empty or its successor moves on
   always_comb begin
      ready[N-1] = !vld_ff[N-1] || !rsp_stall;
      for (int i = N - 2; i >= 0; i--) begin
         ready[i] = !vld_ff[i] || ready[i+1];
      end
      vld_in[0] = req_valid;
      for (int i = 1; i < N; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (ready[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = vld_ff[N-1];

   nnsa_front u_front (
      .clock     (clock),
      .en        (ready[0]),
      .cfg       (cfg_ff),
      .out_x     (req_out_x),
      .out_y     (req_out_y),
      .front_out (front_q)
   );

   nnsa_div u_div (
      .clock    (clock),
      .en       (ready[nnsa_pkg::STG_BACK-1:nnsa_pkg::STG_DIV0]),
      .front_in (front_q),
      .div_x    (cfg_ff.target_width),
      .div_y    (cfg_ff.target_height),
      .side_out (side_q),
      .quot_x   (quot_x),
      .quot_y   (quot_y)
   );

   nnsa_back u_back (
      .clock       (clock),
      .en          (ready[N-1:nnsa_pkg::STG_BACK]),
      .cfg         (cfg_ff),
      .side_in     (side_q),
      .quot_x      (quot_x),
      .quot_y      (quot_y),
      .src_x       (rsp_src_x),
      .src_y       (rsp_src_y),
      .src_offset  (rsp_src_offset),
      .dst_offset  (rsp_dst_offset),
      .coord_valid (rsp_coord_valid)
   );

endmodule

`default_nettype wire

### src/nnsa_checker.sv
// Port-level assertions for the scaling address generator, bound to the top level.
// Depends on nnsa_pkg and nearest_neighbor_scale_address_top.
`default_nettype none

module nnsa_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_valid,
   input wire logic                           req_stall,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_stall,
   input wire logic [nnsa_pkg::DIM_W-1:0]     rsp_src_x,
   input wire logic [nnsa_pkg::DIM_W-1:0]     rsp_src_y,
   input wire logic [nnsa_pkg::OFS_W-1:0]     rsp_src_offset,
   input wire logic [nnsa_pkg::OFS_W-1:0]     rsp_dst_offset,
   input wire logic                           rsp_coord_valid
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_src_offset)
                                 && $stable(rsp_dst_offset))
      else $error("stalled result changed");

   // out-of-frame requests report zero coordinates and offsets
   a_zero_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_coord_valid |-> rsp_src_x == '0 && rsp_src_y == '0
                                        && rsp_src_offset == '0 && rsp_dst_offset == '0)
      else $error("out-of-frame result not cleared");

   // with the output draining, the pipe never pushes back
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while results drain");

   // no result waiting and no request: the input side is open next cycle
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !req_valid && !rsp_stall |=> req_valid || !req_stall)
      else $error("unexpected stall on an idle pipe");

endmodule

bind nearest_neighbor_scale_address_top nnsa_checker u_nnsa_checker (.*);

`default_nettype wire

### tb/tb.sv
// Self-checking bench for the nearest-neighbour scaling address generator.
// Needs nnsa_pkg and nearest_neighbor_scale_address_top; predicts each response in-bench unless the table gives it.
// Directed table of requests and register writes first, then random settings and coordinates.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RAND_PHASES = 7;
   localparam int PHASE_ITEMS = 75;
   localparam int LONG_HOLD   = 120;
   localparam int TAIL_CYCLES = 20;

   // index with no register behind it; a write there must change nothing
   localparam logic [nnsa_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   typedef struct packed {
      logic [nnsa_pkg::DIM_W-1:0] src_x;
      logic [nnsa_pkg::DIM_W-1:0] src_y;
      logic [nnsa_pkg::OFS_W-1:0] src_offset;
      logic [nnsa_pkg::OFS_W-1:0] dst_offset;
      logic                       coord_valid;
   } addr_result_type;

   typedef enum logic {ROW_CSR, ROW_REQ} row_kind_type;

   typedef struct packed {
      row_kind_type                   kind;
      logic [nnsa_pkg::CSR_IDX_W-1:0] index;
      logic [nnsa_pkg::DIM_W-1:0]     a;      // register value, or out_x
      logic [nnsa_pkg::DIM_W-1:0]     b;      // out_y
      logic                           typed;  // want holds the result, no prediction needed
      addr_result_type                want;
   } plan_row_type;

   localparam addr_result_type OUTSIDE    = '0;
   localparam addr_result_type ORIGIN     = '{11'd0, 11'd0, 24'd0, 24'd0, 1'b1};
   // 2047x2047 source, 4 bytes, no scaling: (2046 * 2047 + 2046) * 4
   localparam addr_result_type FAR_CORNER =
      '{11'd2046, 11'd2046, 24'd16760832, 24'd16760832, 1'b1};

   plan_row_type plan[$] = '{
      // reset settings: 1x1 source, no scaling, 2 bytes per pixel
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, ORIGIN},
      '{ROW_REQ, '0, 11'd1, 11'd0, 1'b1, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd1, 1'b1, OUTSIDE},
      '{ROW_REQ, '0, 11'd2047, 11'd2047, 1'b1, OUTSIDE},
      '{ROW_CSR, CSR_SPARE, 11'd2047, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, ORIGIN},
      // largest source, no scaling
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_WIDTH, 11'd2047, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_HEIGHT, 11'd2047, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_PIXEL_BYTES, 11'd4, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd2046, 11'd2046, 1'b1, FAR_CORNER},
      '{ROW_REQ, '0, 11'd2047, 11'd0, 1'b1, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd2047, 1'b1, OUTSIDE},
      '{ROW_REQ, '0, 11'd1365, 11'd682, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd682, 11'd1365, 1'b0, OUTSIDE},
      // strongest downscale: 2047x2047 onto 1x1
      '{ROW_CSR, nnsa_pkg::CSR_TARGET_WIDTH, 11'd1, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_TARGET_HEIGHT, 11'd1, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_PIXEL_BYTES, 11'd1, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, ORIGIN},
      '{ROW_REQ, '0, 11'd1, 11'd0, 1'b1, OUTSIDE},
      // strongest upscale: 1x1 onto 2047x2047
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_WIDTH, 11'd1, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_HEIGHT, 11'd1, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_TARGET_WIDTH, 11'd2047, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_TARGET_HEIGHT, 11'd2047, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_PIXEL_BYTES, 11'd3, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd2046, 11'd2046, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd2047, 11'd2047, 1'b1, OUTSIDE},
      '{ROW_REQ, '0, 11'd1023, 11'd1024, 1'b0, OUTSIDE},
      // zero target height alone turns scaling off
      '{ROW_CSR, nnsa_pkg::CSR_TARGET_HEIGHT, 11'd0, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd5, 11'd0, 1'b1, OUTSIDE},
      // bad pixel sizes
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_WIDTH, 11'd2047, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_HEIGHT, 11'd3, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_TARGET_HEIGHT, 11'd2047, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_PIXEL_BYTES, 11'd0, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_PIXEL_BYTES, 11'd5, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_PIXEL_BYTES, 11'd7, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_PIXEL_BYTES, 11'd2, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd100, 11'd200, 1'b0, OUTSIDE},
      // empty source on either axis
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_WIDTH, 11'd0, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_WIDTH, 11'd5, 11'd0, 1'b0, OUTSIDE},
      '{ROW_CSR, nnsa_pkg::CSR_SOURCE_HEIGHT, 11'd0, 11'd0, 1'b0, OUTSIDE},
      '{ROW_REQ, '0, 11'd0, 11'd0, 1'b1, OUTSIDE}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_wr_en = 1'b0;
   logic [nnsa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [nnsa_pkg::DIM_W-1:0]     csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [nnsa_pkg::DIM_W-1:0]     req_out_x = '0;
   logic [nnsa_pkg::DIM_W-1:0]     req_out_y = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [nnsa_pkg::DIM_W-1:0]     rsp_src_x;
   logic [nnsa_pkg::DIM_W-1:0]     rsp_src_y;
   logic [nnsa_pkg::OFS_W-1:0]     rsp_src_offset;
   logic [nnsa_pkg::OFS_W-1:0]     rsp_dst_offset;
   logic                           rsp_coord_valid;

   nnsa_pkg::cfg_type scale_cfg = nnsa_pkg::CFG_RESET;
   addr_result_type   pending_addr[$];
   int                errors = 0;
   int                checked = 0;
   int                inside_hits = 0;
   int                settings_seen = 1;
   int                hold_asks = 0;
   int                calm_left = 0;

   nearest_neighbor_scale_address_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_out_x       (req_out_x),
      .req_out_y       (req_out_y),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_src_x       (rsp_src_x),
      .rsp_src_y       (rsp_src_y),
      .rsp_src_offset  (rsp_src_offset),
      .rsp_dst_offset  (rsp_dst_offset),
      .rsp_coord_valid (rsp_coord_valid)
   );

   always #5 clock = ~clock;

   // active frame: target size when both target dimensions are set, else source size
   function automatic void frame_of(input nnsa_pkg::cfg_type c,
                                    output logic [nnsa_pkg::DIM_W-1:0] w,
                                    output logic [nnsa_pkg::DIM_W-1:0] h);
      if (c.target_width != 0 && c.target_height != 0) begin
         w = c.target_width;
         h = c.target_height;
      end else begin
         w = c.source_width;
         h = c.source_height;
      end
   endfunction

   function automatic addr_result_type predict_address(input nnsa_pkg::cfg_type c,
                                                       input logic [nnsa_pkg::DIM_W-1:0] ox,
                                                       input logic [nnsa_pkg::DIM_W-1:0] oy);
      addr_result_type            r;
      logic [nnsa_pkg::DIM_W-1:0] fw, fh;
      bit [63:0]                  sw, sh, pb, sx, sy;
      r = '0;
      frame_of(c, fw, fh);
      sw = 64'(c.source_width);
      sh = 64'(c.source_height);
      pb = 64'(c.pixel_bytes);
      if (sw == 0 || sh == 0 || pb == 0 || c.pixel_bytes > nnsa_pkg::PB_MAX
          || ox >= fw || oy >= fh)
         return r;
      if (c.target_width != 0 && c.target_height != 0) begin
         sx = (64'(ox) * sw) / 64'(c.target_width);
         sy = (64'(oy) * sh) / 64'(c.target_height);
      end else begin
         sx = 64'(ox);
         sy = 64'(oy);
      end
      r.src_x       = sx[nnsa_pkg::DIM_W-1:0];
      r.src_y       = sy[nnsa_pkg::DIM_W-1:0];
      r.src_offset  = nnsa_pkg::OFS_W'((sy * sw + sx) * pb);
      r.dst_offset  = nnsa_pkg::OFS_W'((64'(oy) * 64'(fw) + 64'(ox)) * pb);
      r.coord_valid = 1'b1;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [nnsa_pkg::DIM_W-1:0] pick_dim();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return nnsa_pkg::DIM_W'($urandom_range(1, 16));
      if (r < 75) return nnsa_pkg::DIM_W'($urandom_range(1, 2047));
      if (r < 85) return 11'd2047;
      if (r < 95) return 11'd1;
      return 11'd0;
   endfunction

   // mostly inside the frame, some on its edge, the rest anywhere
   function automatic logic [nnsa_pkg::DIM_W-1:0] pick_coord(
         input logic [nnsa_pkg::DIM_W-1:0] lim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 75 && lim != 0) return nnsa_pkg::DIM_W'($urandom_range(0, lim - 1));
      if (r < 88) return lim - nnsa_pkg::DIM_W'($urandom_range(0, 1));
      return nnsa_pkg::DIM_W'($urandom_range(0, 2047));
   endfunction

   task automatic wait_for_results();
      if (req_valid) req_valid <= 1'b0;
      while (pending_addr.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [nnsa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nnsa_pkg::DIM_W-1:0] value);
      wait_for_results();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         nnsa_pkg::CSR_SOURCE_WIDTH:  scale_cfg.source_width  = value;
         nnsa_pkg::CSR_SOURCE_HEIGHT: scale_cfg.source_height = value;
         nnsa_pkg::CSR_TARGET_WIDTH:  scale_cfg.target_width  = value;
         nnsa_pkg::CSR_TARGET_HEIGHT: scale_cfg.target_height = value;
         nnsa_pkg::CSR_PIXEL_BYTES:
            scale_cfg.pixel_bytes = value[nnsa_pkg::PB_W-1:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic offer(input logic [nnsa_pkg::DIM_W-1:0] x,
                        input logic [nnsa_pkg::DIM_W-1:0] y,
                        input addr_result_type want);
      int gap;
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_out_x <= x;
      req_out_y <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_addr.push_back(want);
   endtask

   // stimulus
   initial begin
      plan_row_type               row;
      addr_result_type            want;
      logic [nnsa_pkg::DIM_W-1:0] fw, fh, x, y;
      int                         phase, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            write_reg(row.index, row.a);
         end else begin
            want = row.typed ? row.want : predict_address(scale_cfg, row.a, row.b);
            offer(row.a, row.b, want);
         end
      end

      for (phase = 0; phase < RAND_PHASES; phase++) begin
         write_reg(nnsa_pkg::CSR_SOURCE_WIDTH, pick_dim());
         write_reg(nnsa_pkg::CSR_SOURCE_HEIGHT, pick_dim());
         write_reg(nnsa_pkg::CSR_TARGET_WIDTH,
                   ($urandom_range(0, 3) == 0) ? 11'd0 : pick_dim());
         write_reg(nnsa_pkg::CSR_TARGET_HEIGHT,
                   ($urandom_range(0, 3) == 0) ? 11'd0 : pick_dim());
         // upper bits of the pixel size write are junk the block must ignore
         write_reg(nnsa_pkg::CSR_PIXEL_BYTES, {8'($urandom_range(0, 255)),
                   3'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 4)
                                                  : $urandom_range(0, 7))});
         settings_seen++;
         frame_of(scale_cfg, fw, fh);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 2 && n == 20) hold_asks++;
            if (phase == 4 && n == 40) wait_for_results();
            x = pick_coord(fw);
            y = pick_coord(fh);
            offer(x, y, predict_address(scale_cfg, x, y));
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d responses (%0d inside the frame) across %0d register settings,",
               checked, inside_hits, settings_seen);
      $display("including scaling off, both scale extremes, bad pixel sizes and empty sources.");
      if (errors == 0 && pending_addr.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // response stall: random bursts, calm stretches and one long hold on request
   initial begin
      int stall_left, free_left, hold_left, hold_seen;
      logic stall_next;
      stall_left = 0;
      free_left  = 0;
      hold_left  = 0;
      hold_seen  = 0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            stall_next = 1'b0;
         end else begin
            stall_next = 1'b0;
            stall_left = pick_gap();
            free_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(0, 4);
         end
         rsp_stall <= stall_next;
      end
   end

   // response checker
   always @(posedge clock) begin
      addr_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_src_x, rsp_src_y, rsp_src_offset, rsp_dst_offset, rsp_coord_valid};
         if (pending_addr.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = pending_addr.pop_front();
            checked++;
            if (want.coord_valid) inside_hits++;
            if (got.src_x !== want.src_x) begin
               $error("src_x expected %0d got %0d", want.src_x, got.src_x);
               errors++;
            end
            if (got.src_y !== want.src_y) begin
               $error("src_y expected %0d got %0d", want.src_y, got.src_y);
               errors++;
            end
            if (got.src_offset !== want.src_offset) begin
               $error("src_offset expected %0d got %0d", want.src_offset, got.src_offset);
               errors++;
            end
            if (got.dst_offset !== want.dst_offset) begin
               $error("dst_offset expected %0d got %0d", want.dst_offset, got.dst_offset);
               errors++;
            end
            if (got.coord_valid !== want.coord_valid) begin
               $error("coord_valid expected %0d got %0d", want.coord_valid, got.coord_valid);
               errors++;
            end
         end
      end
   end

   // watchdog
   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

endmodule

### nearest_neighbor_scale_address_top.f
src/nnsa_pkg.sv
src/nnsa_front.sv
src/nnsa_div.sv
src/nnsa_back.sv
src/nearest_neighbor_scale_address_top.sv
src/nnsa_checker.sv
tb/tb.sv
